// ----- hdl/ean13_pkg.sv -----
// ----------------------------------------------------------------------------
// ean13_pkg
// Shared types, constants and code tables for the EAN-13 pattern encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ean13_pkg;

    localparam int unsigned QueueDepth = 2;
    localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
    localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

    localparam logic [3:0] LastPosition  = 4'd12;
    localparam logic [3:0] CenterPosition = 4'd6;
    localparam logic [3:0] MaxDigit      = 4'd9;

    localparam logic [6:0] EdgeGuard   = 7'b0000101;
    localparam logic [6:0] CenterGuard = 7'b0001010;
    localparam logic [6:0] AllModules  = 7'b1111111;

    localparam logic [2:0] EdgeCount   = 3'd3;
    localparam logic [2:0] CenterCount = 3'd5;
    localparam logic [2:0] DigitCount  = 3'd7;

    // Guard that follows the digit result of an item
    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_CENTER,
        TAIL_END
    } tail_t;

    // One classified item, as it travels from front to back
    typedef struct packed {
        logic [6:0] pattern;
        logic [2:0] count;
        logic       guard;
        logic       err;
        tail_t      tail;
    } cmd_t;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic                 full;
        logic                 empty;
        logic [QueueCntW-1:0] level;
    } queue_status_t;

    // L code of a decimal digit; zero for codes that are not digits
    function automatic logic [6:0] l_code(input logic [3:0] d);
        logic [6:0] c;
        unique case (d)
            4'd0:    c = 7'h0D;
            4'd1:    c = 7'h19;
            4'd2:    c = 7'h13;
            4'd3:    c = 7'h3D;
            4'd4:    c = 7'h23;
            4'd5:    c = 7'h31;
            4'd6:    c = 7'h2F;
            4'd7:    c = 7'h3B;
            4'd8:    c = 7'h37;
            4'd9:    c = 7'h0B;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    // L/G parity selection of a leading digit
    function automatic logic [5:0] parity_code(input logic [3:0] d);
        logic [5:0] p;
        unique case (d)
            4'd0:    p = 6'h00;
            4'd1:    p = 6'h0B;
            4'd2:    p = 6'h0D;
            4'd3:    p = 6'h0E;
            4'd4:    p = 6'h13;
            4'd5:    p = 6'h19;
            4'd6:    p = 6'h1C;
            4'd7:    p = 6'h15;
            4'd8:    p = 6'h16;
            4'd9:    p = 6'h1A;
            default: p = 6'h00;
        endcase
        return p;
    endfunction

    // Reverse the order of seven module bits
    function automatic logic [6:0] mirror7(input logic [6:0] v);
        logic [6:0] r;
        for (int k = 0; k < 7; k++) begin
            r[6-k] = v[k];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/ean13_front.sv -----
// ----------------------------------------------------------------------------
// ean13_front
// Tracks the digit position and parity of the current code and turns each
// accepted digit into one command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ean13_front
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire logic [3:0]            digit_value,
    input  wire logic                  code_start,
    output ean13_pkg::cmd_t            cmd
);

    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic [5:0] parity_reg;
    logic [5:0] parity_next;

    logic [3:0] pos_eff;
    logic       err;
    logic [6:0] lc;
    logic [6:0] rc;
    logic [2:0] par_idx;
    logic       use_g;

    // Resolve the position, error flag, codes and parity choice of this digit
    always_comb
    begin
        pos_eff = (code_start || pos_reg > ean13_pkg::LastPosition) ? 4'd0 : pos_reg;
        err     = digit_value > ean13_pkg::MaxDigit;
        lc      = ean13_pkg::l_code(digit_value);
        rc      = lc ^ ean13_pkg::AllModules;
        par_idx = 3'(ean13_pkg::CenterPosition - pos_eff);
        use_g   = parity_reg[par_idx];
    end

    // Classify the digit and advance the position
    always_comb
    begin
        cmd.err     = err;
        cmd.tail    = ean13_pkg::TAIL_NONE;
        pos_next    = pos_reg;
        parity_next = parity_reg;
        if (pos_eff == 4'd0)
        begin
            cmd.pattern = ean13_pkg::EdgeGuard;
            cmd.count   = ean13_pkg::EdgeCount;
            cmd.guard   = 1'b1;
            pos_next    = 4'd1;
            parity_next = err ? 6'd0 : ean13_pkg::parity_code(digit_value);
        end
        else
        begin
            cmd.count = ean13_pkg::DigitCount;
            cmd.guard = 1'b0;
            priority if (err)
                cmd.pattern = 7'd0;
            else if (pos_eff <= ean13_pkg::CenterPosition)
                cmd.pattern = use_g ? ean13_pkg::mirror7(rc) : lc;
            else
                cmd.pattern = rc;
            if (pos_eff == ean13_pkg::CenterPosition)
                cmd.tail = ean13_pkg::TAIL_CENTER;
            else if (pos_eff == ean13_pkg::LastPosition)
                cmd.tail = ean13_pkg::TAIL_END;
            pos_next = (pos_eff == ean13_pkg::LastPosition) ? 4'd0 : pos_eff + 4'd1;
        end
    end

    // Hold code state between digits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 4'd0;
            parity_reg <= 6'd0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            parity_reg <= parity_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ean13_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// ean13_cmd_queue
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ean13_cmd_queue
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  ean13_pkg::cmd_t            wr_cmd,
    input  wire logic                  rd_en,
    output ean13_pkg::cmd_t            rd_cmd,
    output ean13_pkg::queue_status_t   status
);

    ean13_pkg::cmd_t                         entries_reg [ean13_pkg::QueueDepth];
    logic [ean13_pkg::QueuePtrW-1:0]         wr_ptr_reg;
    logic [ean13_pkg::QueuePtrW-1:0]         rd_ptr_reg;
    logic [ean13_pkg::QueueCntW-1:0]         count_reg;
    logic [ean13_pkg::QueueCntW-1:0]         count_next;

    localparam logic [ean13_pkg::QueuePtrW-1:0] LastSlot =
        ean13_pkg::QueuePtrW'(ean13_pkg::QueueDepth - 1);

    assign status.full  = count_reg == ean13_pkg::QueueCntW'(ean13_pkg::QueueDepth);
    assign status.empty = count_reg == '0;
    assign status.level = count_reg;
    assign rd_cmd       = entries_reg[rd_ptr_reg];

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == LastSlot) ? '0 : wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == LastSlot) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Store written commands
    always_ff @(posedge clk)
    begin
        if (wr_en)
            entries_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

`default_nettype wire

// ----- hdl/ean13_back.sv -----
// ----------------------------------------------------------------------------
// ean13_back
// Expands each command into one or two result patterns and holds the
// current result for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module ean13_back
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  ean13_pkg::cmd_t            q_cmd,
    input  wire logic                  q_empty,
    output logic                       q_rd,
    input  wire logic                  pop,
    output logic                       empty,
    output logic [6:0]                 bar_pattern,
    output logic [2:0]                 module_count,
    output logic                       is_guard,
    output logic                       digit_error,
    output logic                       last_of_run
);

    ean13_pkg::cmd_t cur_reg;
    logic            valid_reg;
    logic            valid_next;
    logic            tail_reg;
    logic            tail_next;
    logic            done;

    // Present the digit part or the trailing guard
    always_comb
    begin
        digit_error = cur_reg.err;
        if (tail_reg)
        begin
            is_guard    = 1'b1;
            last_of_run = 1'b1;
            unique case (cur_reg.tail)
                ean13_pkg::TAIL_CENTER:
                begin
                    bar_pattern  = ean13_pkg::CenterGuard;
                    module_count = ean13_pkg::CenterCount;
                end
                default:
                begin
                    bar_pattern  = ean13_pkg::EdgeGuard;
                    module_count = ean13_pkg::EdgeCount;
                end
            endcase
        end
        else
        begin
            bar_pattern  = cur_reg.pattern;
            module_count = cur_reg.count;
            is_guard     = cur_reg.guard;
            last_of_run  = cur_reg.tail == ean13_pkg::TAIL_NONE;
        end
    end

    assign empty = !valid_reg;

    // Decide when the current command is finished and what comes next
    always_comb
    begin
        done       = !valid_reg || (pop && last_of_run);
        q_rd       = done && !q_empty;
        valid_next = valid_reg;
        tail_next  = tail_reg;
        if (done)
        begin
            valid_next = !q_empty;
            tail_next  = 1'b0;
        end
        else if (pop)
        begin
            tail_next = 1'b1;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tail_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            tail_reg  <= tail_next;
        end
    end

    // Load the next command
    always_ff @(posedge clk)
    begin
        if (q_rd)
            cur_reg <= q_cmd;
    end

endmodule

`default_nettype wire

// ----- hdl/ean13_module_pattern_encoder.sv -----
// ----------------------------------------------------------------------------
// ean13_module_pattern_encoder
// EAN-13 encoder: digits in, bar module patterns and guards out.
// ----------------------------------------------------------------------------
// An accepted digit passes a queue entry and the back end's result register
// before it shows on the result ports. Throughput: one result per cycle while
// pop is held and the queue is not empty; a digit gives one result, or two for
// digits 7 and 13 whose guard follows. The two-entry command queue fills during
// a guard and the input stalls; pop stalls back up through the queue to full.
// Reset clears position, parity, queue and result valid; payload is not reset.
`default_nettype none

module ean13_module_pattern_encoder
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [3:0] digit_value,
    input  wire logic       code_start,
    input  wire logic       pop,
    output logic            empty,
    output logic [6:0]      bar_pattern,
    output logic [2:0]      module_count,
    output logic            is_guard,
    output logic            digit_error,
    output logic            last_of_run
);

    ean13_pkg::cmd_t          front_cmd;
    ean13_pkg::cmd_t          q_cmd;
    ean13_pkg::queue_status_t q_status;
    logic                     accept;
    logic                     q_rd;

    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    // Classify incoming digits
    ean13_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .digit_value (digit_value),
        .code_start  (code_start),
        .cmd         (front_cmd)
    );

    // Buffer commands between front and back
    ean13_cmd_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept),
        .wr_cmd (front_cmd),
        .rd_en  (q_rd),
        .rd_cmd (q_cmd),
        .status (q_status)
    );

    // Expand commands into results
    ean13_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_cmd        (q_cmd),
        .q_empty      (q_status.empty),
        .q_rd         (q_rd),
        .pop          (pop),
        .empty        (empty),
        .bar_pattern  (bar_pattern),
        .module_count (module_count),
        .is_guard     (is_guard),
        .digit_error  (digit_error),
        .last_of_run  (last_of_run)
    );

    // Queue level stays within its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.level <= ean13_pkg::QueueCntW'(ean13_pkg::QueueDepth))
        else $error("command queue overfilled");

    // Digit results are seven modules wide and never guards
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !is_guard) |-> module_count == ean13_pkg::DigitCount)
        else $error("digit result with wrong module count");

    // A center guard always closes its item
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && module_count == ean13_pkg::CenterCount) |-> (is_guard && last_of_run))
        else $error("center guard not last of run");

    // A non-final result is followed by its guard after transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_of_run) |=> (!empty && is_guard && last_of_run))
        else $error("trailing guard missing");

endmodule

`default_nettype wire
